### sv/cmb_pkg.sv
`timescale 1ns / 1ps

package cmb_pkg;

  localparam int CellW  = 10;
  localparam int TempW  = 10;
  localparam int MvW    = 16;
  localparam int LvlW   = 8;
  localparam int CfgW   = 16;
  localparam int CfgIdxW = 3;
  localparam int FlagW  = 3;
  localparam int NumW   = 26;  // adc_ref * 1023 needs 26 bits
  localparam int QuoW   = 16;
  localparam int CntW   = 5;

  localparam int DefQueueDepth = 2;

  // control_flags bit positions
  localparam int CtlFreezePwm = 0;
  localparam int CtlFreezeInd = 1;
  localparam int CtlTimerEn   = 2;

  // register reset values
  localparam logic [CfgW-1:0] RstULow    = 16'd2550;
  localparam logic [CfgW-1:0] RstUMinBal = 16'd3340;
  localparam logic [CfgW-1:0] RstUMaxBal = 16'd3650;
  localparam logic [CfgW-1:0] RstUMinInd = 16'd3000;
  localparam logic [CfgW-1:0] RstUMaxInd = 16'd3300;
  localparam logic [CfgW-1:0] RstAdcRef  = 16'd1112;
  localparam logic [FlagW-1:0] RstCtl    = 3'd0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_U_LOW     = 3'd0,
    REG_U_MIN_BAL = 3'd1,
    REG_U_MAX_BAL = 3'd2,
    REG_U_MIN_IND = 3'd3,
    REG_U_MAX_IND = 3'd4,
    REG_ADC_REF   = 3'd5,
    REG_CONTROL   = 3'd6
  } cmb_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VSTART,
    ST_VWAIT,
    ST_BAL,
    ST_BWAIT,
    ST_IND,
    ST_IWAIT,
    ST_OUT
  } cmb_state_e;

  typedef struct packed {
    logic [CellW-1:0] adc_cell;
    logic             adc_cell_ready;
    logic [TempW-1:0] adc_temp;
    logic             adc_temp_ready;
    logic             rx_active;
  } cmb_in_t;

  typedef struct packed {
    logic [MvW-1:0]   cell_mv;
    logic [TempW-1:0] temperature_raw;
    logic             stop_discharge;
    logic             stop_charge;
    logic             stop_charge_hard;
    logic [LvlW-1:0]  balance_level;
    logic [LvlW-1:0]  balance_pwm;
    logic [LvlW-1:0]  indicator_level;
    logic             led_on;
    logic             power_down;
  } cmb_out_t;

  // classified word as held in the queue
  typedef struct packed {
    logic [CellW-1:0] adc_cell;
    logic             cell_ok;
    logic [TempW-1:0] adc_temp;
    logic             temp_ok;
    logic             rx_active;
  } cmb_item_t;

  typedef struct packed {
    logic            start;
    logic            short_mode;  // 8 quotient bits instead of 16
    logic [NumW-1:0] num;
    logic [MvW-1:0]  den;
  } cmb_div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [QuoW-1:0] quo;
  } cmb_div_rsp_t;

endpackage

### sv/cmb_front.sv
`timescale 1ns / 1ps

module cmb_front import cmb_pkg::*; #(
  parameter int Depth = DefQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  cmb_in_t   in_data_i,
  output logic      item_valid_o,
  input  logic      item_ready_i,
  output cmb_item_t item_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntQW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  cmb_item_t          mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0]   count_q, count_d;
  logic               push, pop;
  cmb_item_t          item_in;

  // classify: a zero reference reading never updates the voltage
  always_comb begin
    item_in.adc_cell = in_data_i.adc_cell;
    item_in.cell_ok  = in_data_i.adc_cell_ready && (in_data_i.adc_cell != '0);
    item_in.adc_temp = in_data_i.adc_temp;
    item_in.temp_ok  = in_data_i.adc_temp_ready;
    item_in.rx_active = in_data_i.rx_active;
  end

  assign in_ready_o   = (count_q != CntQW'(Depth));
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntQW'(Depth))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count missed a pop");

endmodule

### sv/cmb_div.sv
`timescale 1ns / 1ps

module cmb_div import cmb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmb_div_req_t req_i,
  output cmb_div_rsp_t rsp_o
);

  // restoring divider, one quotient bit a cycle; the caller guarantees
  // the quotient fits in 8 (short) or 16 bits
  logic [MvW-1:0]  rem_q, rem_d, low_q, low_d, den_q, den_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [MvW:0]    trial, diff;
  logic            ge;

  assign trial = {rem_q, low_q[MvW-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    low_d  = low_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      den_d  = req_i.den;
      quo_d  = '0;
      busy_d = 1'b1;
      if (req_i.short_mode) begin
        rem_d = req_i.num[23:8];
        low_d = {req_i.num[7:0], 8'h00};
        cnt_d = CntW'(8);
      end else begin
        rem_d = {6'd0, req_i.num[NumW-1:16]};
        low_d = req_i.num[15:0];
        cnt_d = CntW'(16);
      end
    end else if (busy_q) begin
      rem_d = ge ? diff[MvW-1:0] : trial[MvW-1:0];
      low_d = {low_q[MvW-2:0], 1'b0};
      quo_d = {quo_q[QuoW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

### sv/cmb_back.sv
`timescale 1ns / 1ps

module cmb_back import cmb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  cmb_item_t          item_i,
  output cmb_div_req_t       div_req_o,
  input  cmb_div_rsp_t       div_rsp_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cmb_out_t           out_data_o
);

  // configuration registers
  logic [CfgW-1:0]  u_low_q, u_min_bal_q, u_max_bal_q, u_min_ind_q, u_max_ind_q, adc_ref_q;
  logic [FlagW-1:0] ctl_q;

  cmb_state_e state_q, state_d;
  cmb_item_t  cur_q;

  logic [MvW-1:0]   volt_q, timer_q;
  logic [TempW-1:0] temp_q;
  logic [LvlW-1:0]  bal_q, pwm_q, ind_q, led_lvl_q, led_phase_q;
  logic             led_q, pd_q;
  logic             out_valid_q;
  cmb_out_t         out_q;

  logic [MvW-1:0]  timer_base, timer_next;
  logic            pd_next;
  logic [LvlW-1:0] led_lvl_next;
  logic [NumW-1:0] volt_num;
  logic            volt_sat;
  logic [MvW-1:0]  sc_lo, sc_hi, sc_diff, sc_span;
  logic [23:0]     sc_num;
  logic            sc_above, sc_empty, sc_sat;
  logic            out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_low_q     <= RstULow;
      u_min_bal_q <= RstUMinBal;
      u_max_bal_q <= RstUMaxBal;
      u_min_ind_q <= RstUMinInd;
      u_max_ind_q <= RstUMaxInd;
      adc_ref_q   <= RstAdcRef;
      ctl_q       <= RstCtl;
    end else if (cfg_we_i) begin
      case (cmb_reg_e'(cfg_idx_i))
        REG_U_LOW:     u_low_q     <= cfg_wdata_i;
        REG_U_MIN_BAL: u_min_bal_q <= cfg_wdata_i;
        REG_U_MAX_BAL: u_max_bal_q <= cfg_wdata_i;
        REG_U_MIN_IND: u_min_ind_q <= cfg_wdata_i;
        REG_U_MAX_IND: u_max_ind_q <= cfg_wdata_i;
        REG_ADC_REF:   adc_ref_q   <= cfg_wdata_i;
        REG_CONTROL:   ctl_q       <= cfg_wdata_i[FlagW-1:0];
        default: ;
      endcase
    end
  end

  // power-down timer and led, taken from the incoming word
  always_comb begin
    timer_base = item_i.rx_active ? '0 : timer_q;
    timer_next = timer_base;
    pd_next    = 1'b0;
    if (ctl_q[CtlTimerEn]) begin
      timer_next = timer_base + 1'b1;
      pd_next    = (timer_next == '0);
    end
    led_lvl_next = (led_phase_q == '0) ? ind_q : led_lvl_q;
  end

  // voltage: adc_ref * 1023 / cell; saturates when the quotient needs more than 16 bits
  assign volt_num = {adc_ref_q, 10'd0} - {10'd0, adc_ref_q};
  assign volt_sat = (volt_num >= {cur_q.adc_cell, 16'd0});

  // shared span scaling for the balance and the indicator levels
  always_comb begin
    if (state_q == ST_IND) begin
      sc_lo = u_min_ind_q;
      sc_hi = u_max_ind_q;
    end else begin
      sc_lo = u_min_bal_q;
      sc_hi = u_max_bal_q;
    end
  end
  assign sc_above = (volt_q > sc_lo);
  assign sc_empty = (sc_hi <= sc_lo);
  assign sc_diff  = volt_q - sc_lo;
  assign sc_span  = sc_hi - sc_lo;
  assign sc_num   = {sc_diff, 8'd0} - {8'd0, sc_diff};
  assign sc_sat   = (sc_num >= {sc_span, 8'd0});

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_valid_i) state_d = ST_VSTART;
      end
      ST_VSTART: begin
        state_d = (cur_q.cell_ok && !volt_sat) ? ST_VWAIT : ST_BAL;
      end
      ST_VWAIT: begin
        if (div_rsp_i.done) state_d = ST_BAL;
      end
      ST_BAL: begin
        state_d = (sc_above && !sc_empty && !sc_sat) ? ST_BWAIT : ST_IND;
      end
      ST_BWAIT: begin
        if (div_rsp_i.done) state_d = ST_IND;
      end
      ST_IND: begin
        state_d = (!ctl_q[CtlFreezeInd] && sc_above && !sc_empty && !sc_sat)
                  ? ST_IWAIT : ST_OUT;
      end
      ST_IWAIT: begin
        if (div_rsp_i.done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    item_ready_o         = 1'b0;
    div_req_o.start      = 1'b0;
    div_req_o.short_mode = 1'b1;
    div_req_o.num        = {2'd0, sc_num};
    div_req_o.den        = sc_span;
    case (state_q)
      ST_IDLE: item_ready_o = 1'b1;
      ST_VSTART: begin
        div_req_o.start      = cur_q.cell_ok && !volt_sat;
        div_req_o.short_mode = 1'b0;
        div_req_o.num        = volt_num;
        div_req_o.den        = {6'd0, cur_q.adc_cell};
      end
      ST_BAL: div_req_o.start = sc_above && !sc_empty && !sc_sat;
      ST_IND: div_req_o.start = !ctl_q[CtlFreezeInd] && sc_above && !sc_empty && !sc_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      volt_q      <= '0;
      temp_q      <= '0;
      bal_q       <= '0;
      pwm_q       <= '0;
      ind_q       <= '0;
      led_lvl_q   <= '0;
      led_phase_q <= '0;
      timer_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      // a new word takes the output register, or the held word leaves
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (item_valid_i) begin
            timer_q     <= timer_next;
            led_lvl_q   <= led_lvl_next;
            led_phase_q <= led_phase_q + 1'b1;
            if (item_i.temp_ok) temp_q <= item_i.adc_temp;
          end
        end
        ST_VSTART: begin
          if (cur_q.cell_ok && volt_sat) volt_q <= '1;
        end
        ST_VWAIT: begin
          if (div_rsp_i.done) volt_q <= div_rsp_i.quo;
        end
        ST_BAL: begin
          if (sc_above) begin
            timer_q <= '0;
            if (sc_empty || sc_sat) begin
              bal_q <= '1;
              if (!ctl_q[CtlFreezePwm]) pwm_q <= '1;
            end
          end else if (!ctl_q[CtlFreezePwm]) begin
            pwm_q <= '0;
          end
        end
        ST_BWAIT: begin
          if (div_rsp_i.done) begin
            bal_q <= div_rsp_i.quo[LvlW-1:0];
            if (!ctl_q[CtlFreezePwm]) pwm_q <= div_rsp_i.quo[LvlW-1:0];
          end
        end
        ST_IND: begin
          if (!ctl_q[CtlFreezeInd]) begin
            if (!sc_above) begin
              ind_q <= '0;
            end else if (sc_empty || sc_sat) begin
              ind_q <= '1;
            end
          end
        end
        ST_IWAIT: begin
          if (div_rsp_i.done) ind_q <= div_rsp_i.quo[LvlW-1:0];
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && item_valid_i) begin
      cur_q <= item_i;
      pd_q  <= pd_next;
      led_q <= (led_phase_q <= led_lvl_next);
    end
    if (state_q == ST_OUT && out_free) begin
      out_q.cell_mv          <= volt_q;
      out_q.temperature_raw  <= temp_q;
      out_q.stop_discharge   <= (volt_q < u_low_q);
      out_q.stop_charge      <= (volt_q > u_min_bal_q);
      out_q.stop_charge_hard <= (volt_q > u_max_bal_q);
      out_q.balance_level    <= bal_q;
      out_q.balance_pwm      <= pwm_q;
      out_q.indicator_level  <= ind_q;
      out_q.led_on           <= led_q;
      out_q.power_down       <= pd_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### sv/cell_monitor_balancer.sv
`timescale 1ns / 1ps

// cell monitor with passive balancer, one poll tick per input word
// in channel: in_valid_i / in_ready_o with in_data_i carrying the raw
//   reference and thermistor readings, their fresh flags and rx activity
// out channel: out_valid_o / out_ready_i with out_data_o carrying the held
//   cell millivolts, temperature, stop flags, balance, pwm, indicator,
//   led drive and the power-down pulse; exactly one word out per word in
// config: cfg_we_i writes cfg_wdata_i to register cfg_idx_i at once
//   (0 u_low .. 5 adc_ref, 6 control flags); index 7 is ignored;
//   write only while no word is in flight
// path: from input word to output word, up to three divisions run on the
//   shared bit-serial divider (16 quotient bits for the voltage, 8 each for
//   the two span scalings); saturated or skipped divisions shorten the path
// flow: one word at a time in the back end; a two-word queue takes up to
//   two more words meanwhile
// reset: the held voltage, temperature and levels and the led and timer
//   counters clear to zero, registers take their documented defaults
// stall: a finished word waits in the output register; the back end then
//   stops before loading the next result, the queue fills and in_ready_o drops
module cell_monitor_balancer import cmb_pkg::*; #(
  parameter int QueueDepth = DefQueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cmb_in_t            in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cmb_out_t           out_data_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i
);

  logic         item_valid, item_ready;
  cmb_item_t    item;
  cmb_div_req_t div_req;
  cmb_div_rsp_t div_rsp;

  // front: classify the raw flags and queue the word
  cmb_front #(
    .Depth(QueueDepth)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .item_valid_o(item_valid),
    .item_ready_i(item_ready),
    .item_o      (item)
  );

  // shared divider for the voltage and both span scalings
  cmb_div u_div (
    .clk_i,
    .rst_ni,
    .req_i(div_req),
    .rsp_o(div_rsp)
  );

  // back: sequencer, held state, configuration and output register
  cmb_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .item_valid_i(item_valid),
    .item_ready_o(item_ready),
    .item_i      (item),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

endmodule
